>>> hw/rtl/usce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usce_pkg: shared types and constants of the cubic spline evaluator
// Sizes, coefficient select codes, opcodes and the beat types that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package usce_pkg;

   // sizes
   localparam int MAX_SEGMENTS = 1024;
   localparam int SEG_W        = $clog2(MAX_SEGMENTS);
   localparam int WORD_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int NSEG_W       = 11;
   localparam int LOAD_SEG_W   = 10;
   localparam int WHICH_W      = 4;
   localparam int DIV_W        = WORD_W + SEG_W;
   localparam int PROD_W       = 2 * WORD_W;

   // front pipeline: entry, one stage per quotient bit, clamp, multiply, offset
   localparam int FRONT_DEPTH  = SEG_W + 4;
   localparam int QUEUE_DEPTH  = 1 << $clog2(FRONT_DEPTH + 2);
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // horner evaluation lanes
   localparam int NUM_LANES    = 3;
   localparam int HORNER_STEPS = 3;
   localparam int BACK_STAGES  = 2 * HORNER_STEPS;
   localparam int NUM_COEFS    = 9;

   localparam int LANE_VALUE     = 0;
   localparam int LANE_SLOPE     = 1;
   localparam int LANE_CURVATURE = 2;

   // opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // configuration register indexes
   localparam int   CSR_INDEX_W      = 1;
   localparam logic CSR_GRID_SPACING = 1'b0;
   localparam logic CSR_NUM_SEGMENTS = 1'b1;

   // coefficient select codes (load_which), plus a code for a constant zero
   localparam logic [WHICH_W-1:0] COEF_A    = 4'd0;
   localparam logic [WHICH_W-1:0] COEF_B    = 4'd1;
   localparam logic [WHICH_W-1:0] COEF_C    = 4'd2;
   localparam logic [WHICH_W-1:0] COEF_D    = 4'd3;
   localparam logic [WHICH_W-1:0] COEF_DB   = 4'd4;
   localparam logic [WHICH_W-1:0] COEF_DC   = 4'd5;
   localparam logic [WHICH_W-1:0] COEF_DD   = 4'd6;
   localparam logic [WHICH_W-1:0] COEF_DDC  = 4'd7;
   localparam logic [WHICH_W-1:0] COEF_DDD  = 4'd8;
   localparam logic [WHICH_W-1:0] COEF_NONE = 4'd9;

   // per lane: start value, then the coefficient added at each horner step;
   // shorter polynomials are padded with leading zero steps
   localparam logic [WHICH_W-1:0] COEF_SEL [NUM_LANES][HORNER_STEPS+1] = '{
      '{COEF_D,    COEF_C,    COEF_B,   COEF_A},
      '{COEF_NONE, COEF_DD,   COEF_DC,  COEF_DB},
      '{COEF_NONE, COEF_NONE, COEF_DDD, COEF_DDC}
   };

   typedef logic [NUM_LANES-1:0][HORNER_STEPS:0][WORD_W-1:0] coef_mat_type;

   // item handed from the front end to the back end
   typedef struct packed {
      logic                     op;
      logic [SEG_W-1:0]         m;
      logic [WORD_W-1:0]        p;
      logic [LOAD_SEG_W-1:0]    load_segment;
      logic [WHICH_W-1:0]       load_which;
      logic [WORD_W-1:0]        load_value;
   } queue_item_type;

   typedef struct packed {
      logic           valid;
      queue_item_type item;
   } queue_beat_type;

   // one stage of the segment divider
   typedef struct packed {
      logic                  op;
      logic [WORD_W-1:0]     x;
      logic [LOAD_SEG_W-1:0] load_segment;
      logic [WHICH_W-1:0]    load_which;
      logic [WORD_W-1:0]     load_value;
      logic                  sat;
      logic [WORD_W-1:0]     rem;
      logic [SEG_W-1:0]      q;
   } div_stage_type;

   // stage after the segment is known
   typedef struct packed {
      logic                  op;
      logic [WORD_W-1:0]     x;
      logic [SEG_W-1:0]      m;
      logic [LOAD_SEG_W-1:0] load_segment;
      logic [WHICH_W-1:0]    load_which;
      logic [WORD_W-1:0]     load_value;
   } seg_stage_type;

endpackage
`default_nettype wire

>>> hw/rtl/usce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usce_ram: generic single write port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module usce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/usce_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usce_front: request intake and segment/offset pipeline
// Finds the segment index by a restoring divider, one quotient bit a stage,
// clamps it, forms the offset inside the segment and hands the beat on.
// ----------------------------------------------------------------------------
module usce_front
   import usce_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_op,
   input  wire logic [WORD_W-1:0]     req_position,
   input  wire logic [LOAD_SEG_W-1:0] req_load_segment,
   input  wire logic [WHICH_W-1:0]    req_load_which,
   input  wire logic [WORD_W-1:0]     req_load_value,
   input  wire logic [WORD_W-1:0]     grid_spacing,
   input  wire logic [NSEG_W-1:0]     num_segments,
   input  wire logic                  pop,
   output      queue_beat_type        push
);

   logic                     accept;
   logic [QCNT_W-1:0]        used_ff;
   logic [QCNT_W-1:0]        used_in;
   logic [FRONT_DEPTH-1:0]   valid_ff;
   div_stage_type            div_ff [SEG_W+1];
   div_stage_type            div_in [SEG_W+1];
   seg_stage_type            clamp_ff;
   seg_stage_type            clamp_in;
   seg_stage_type            mul_ff;
   logic [DIV_W-1:0]         mul_prod_ff;
   logic [DIV_W-1:0]         mul_prod_in;
   queue_item_type           out_ff;
   queue_item_type           out_in;
   logic [WORD_W-1:0]        nseg_eff;
   logic [SEG_W-1:0]         seg_last;
   logic [WORD_W-1:0]        diff;

   // credit: items in flight plus items queued never exceed the queue depth
   assign accept    = req_valid && !req_stall;
   assign req_stall = (used_ff == QCNT_W'(QUEUE_DEPTH));
   assign used_in   = used_ff + QCNT_W'(accept) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         valid_ff <= '0;
      end else begin
         used_ff  <= used_in;
         valid_ff <= {valid_ff[FRONT_DEPTH-2:0], accept};
      end
   end

   // last segment in use, segment count clamped to 1..MAX_SEGMENTS
   always_comb begin
      nseg_eff = WORD_W'(num_segments);
      if (nseg_eff == '0) begin
         nseg_eff = WORD_W'(1);
      end else if (nseg_eff > WORD_W'(MAX_SEGMENTS)) begin
         nseg_eff = WORD_W'(MAX_SEGMENTS);
      end
      seg_last = SEG_W'(nseg_eff - WORD_W'(1));
   end

   // entry stage and restoring divide steps
   always_comb begin
      logic [DIV_W-1:0] dsh;
      logic [DIV_W-1:0] rem_ext;
      div_in[0].op           = req_op;
      div_in[0].x            = req_position;
      div_in[0].load_segment = req_load_segment;
      div_in[0].load_which   = req_load_which;
      div_in[0].load_value   = req_load_value;
      div_in[0].sat          = ({{SEG_W{1'b0}}, req_position} >= {grid_spacing, {SEG_W{1'b0}}});
      div_in[0].rem          = req_position;
      div_in[0].q            = '0;
      for (int k = 1; k <= SEG_W; k++) begin
         dsh     = DIV_W'(grid_spacing) << (SEG_W - k);
         rem_ext = DIV_W'(div_ff[k-1].rem);
         div_in[k] = div_ff[k-1];
         if (rem_ext >= dsh) begin
            div_in[k].rem            = div_ff[k-1].rem - dsh[WORD_W-1:0];
            div_in[k].q[SEG_W - k]   = 1'b1;
         end
      end
   end

   // clamp segment to the last one in use
   always_comb begin
      clamp_in.op           = div_ff[SEG_W].op;
      clamp_in.x            = div_ff[SEG_W].x;
      clamp_in.load_segment = div_ff[SEG_W].load_segment;
      clamp_in.load_which   = div_ff[SEG_W].load_which;
      clamp_in.load_value   = div_ff[SEG_W].load_value;
      if (div_ff[SEG_W].sat || (div_ff[SEG_W].q > seg_last)) begin
         clamp_in.m = seg_last;
      end else begin
         clamp_in.m = div_ff[SEG_W].q;
      end
   end

   // segment start and offset inside the segment, clamped to the spacing
   assign mul_prod_in = DIV_W'(clamp_ff.m) * DIV_W'(grid_spacing);
   assign diff        = mul_ff.x - mul_prod_ff[WORD_W-1:0];

   always_comb begin
      out_in.op           = mul_ff.op;
      out_in.m            = mul_ff.m;
      out_in.load_segment = mul_ff.load_segment;
      out_in.load_which   = mul_ff.load_which;
      out_in.load_value   = mul_ff.load_value;
      out_in.p            = (diff > grid_spacing) ? grid_spacing : diff;
   end

   // payload stages
   always_ff @(posedge clock) begin
      for (int k = 0; k <= SEG_W; k++) begin
         div_ff[k] <= div_in[k];
      end
      clamp_ff    <= clamp_in;
      mul_ff      <= clamp_ff;
      mul_prod_ff <= mul_prod_in;
      out_ff      <= out_in;
   end

   assign push.valid = valid_ff[FRONT_DEPTH-1];
   assign push.item  = out_ff;

`ifndef ASSERT_OFF
   a_used_covers_pipe: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= int'(used_ff))
      else $error("front pipeline holds more beats than the credit count");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/usce_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usce_queue: decoupling queue between front and back end
// Small register queue; the front end never pushes into a full queue
// because of its credit count.
// ----------------------------------------------------------------------------
module usce_queue
   import usce_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_beat_type push,
   input  wire logic           pop,
   output      queue_beat_type head
);

   queue_item_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && !pop && (count_ff == QCNT_W'(QUEUE_DEPTH))))
      else $error("push into a full queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/usce_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// usce_back: coefficient tables and horner evaluation
// Takes beats from the queue in order, writes loads into the nine
// coefficient RAMs, reads them for evaluations and runs three lanes of
// multiply/add horner steps into the result register.
// ----------------------------------------------------------------------------
module usce_back
   import usce_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_beat_type     head,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [WORD_W-1:0]  rsp_spline_value,
   output      logic [WORD_W-1:0]  rsp_spline_slope,
   output      logic [WORD_W-1:0]  rsp_spline_curvature
);

   logic                    adv;
   logic                    pop_eval;
   logic                    load_ok;
   logic [NUM_COEFS-1:0]    ram_we;
   logic [WORD_W-1:0]       rd_word [NUM_COEFS];
   coef_mat_type            cm0;
   logic [BACK_STAGES:0]    valid_ff;
   logic [WORD_W-1:0]       p_ff   [BACK_STAGES-1];
   coef_mat_type            cm_ff  [1:BACK_STAGES-1];
   logic [WORD_W-1:0]       mul_src [HORNER_STEPS][NUM_LANES];
   logic [PROD_W-1:0]       prod_ff [HORNER_STEPS][NUM_LANES];
   logic [PROD_W-1:0]       prod_in [HORNER_STEPS][NUM_LANES];
   logic [WORD_W-1:0]       acc_ff  [1:HORNER_STEPS][NUM_LANES];
   logic [WORD_W-1:0]       acc_in  [1:HORNER_STEPS][NUM_LANES];

   // saturate a widened sum to the signed word range
   function automatic logic [WORD_W-1:0] sat_word(input logic [PROD_W-FRAC_W:0] s);
      logic [WORD_W-1:0] r;
      if ((s[PROD_W-FRAC_W:WORD_W-1] == '0) || (s[PROD_W-FRAC_W:WORD_W-1] == '1)) begin
         r = s[WORD_W-1:0];
      end else if (s[PROD_W-FRAC_W]) begin
         r = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(WORD_W-1){1'b1}}};
      end
      return r;
   endfunction

   // whole back end moves together unless a result is held
   assign rsp_valid = valid_ff[BACK_STAGES];
   assign adv       = !(rsp_valid && rsp_stall);
   assign pop       = adv && head.valid;
   assign pop_eval  = pop && (head.item.op == OP_EVAL);
   assign load_ok   = pop && (head.item.op == OP_LOAD)
                      && (WORD_W'(head.item.load_segment) < WORD_W'(MAX_SEGMENTS));

   // write select per coefficient table
   always_comb begin
      for (int i = 0; i < NUM_COEFS; i++) begin
         ram_we[i] = load_ok && (head.item.load_which == WHICH_W'(i));
      end
   end

   // coefficient tables
   for (genvar i = 0; i < NUM_COEFS; i++) begin : g_coef_ram
      usce_ram #(
         .WIDTH (WORD_W),
         .DEPTH (MAX_SEGMENTS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[i]),
         .wr_addr (SEG_W'(head.item.load_segment)),
         .wr_data (head.item.load_value),
         .rd_en   (adv),
         .rd_addr (head.item.m),
         .rd_data (rd_word[i])
      );
   end

   // arrange table words into lane start values and step coefficients
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         for (int k = 0; k <= HORNER_STEPS; k++) begin
            if (COEF_SEL[l][k] == COEF_NONE) begin
               cm0[l][k] = '0;
            end else begin
               cm0[l][k] = rd_word[COEF_SEL[l][k]];
            end
         end
      end
   end

   // horner steps: multiply by p, then floor shift, add and saturate
   always_comb begin
      logic signed [PROD_W:0]        full;
      logic signed [PROD_W-FRAC_W:0] sum;
      for (int l = 0; l < NUM_LANES; l++) begin
         mul_src[0][l] = cm0[l][0];
         for (int j = 1; j < HORNER_STEPS; j++) begin
            mul_src[j][l] = acc_ff[j][l];
         end
      end
      for (int j = 0; j < HORNER_STEPS; j++) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            full          = $signed(mul_src[j][l]) * $signed({1'b0, p_ff[2*j]});
            prod_in[j][l] = full[PROD_W-1:0];
            sum = $signed({prod_ff[j][l][PROD_W-1], prod_ff[j][l][PROD_W-1:FRAC_W]})
                + $signed({{(PROD_W-FRAC_W-WORD_W+1){cm_ff[2*j+1][l][j+1][WORD_W-1]}},
                           cm_ff[2*j+1][l][j+1]});
            acc_in[j+1][l] = sat_word(sum);
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[BACK_STAGES-1:0], pop_eval};
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff[0]  <= head.item.p;
         for (int s = 1; s < BACK_STAGES - 1; s++) begin
            p_ff[s] <= p_ff[s-1];
         end
         cm_ff[1] <= cm0;
         for (int s = 2; s < BACK_STAGES; s++) begin
            cm_ff[s] <= cm_ff[s-1];
         end
         for (int j = 0; j < HORNER_STEPS; j++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               prod_ff[j][l]  <= prod_in[j][l];
               acc_ff[j+1][l] <= acc_in[j+1][l];
            end
         end
      end
   end

   assign rsp_spline_value     = acc_ff[HORNER_STEPS][LANE_VALUE];
   assign rsp_spline_slope     = acc_ff[HORNER_STEPS][LANE_SLOPE];
   assign rsp_spline_curvature = acc_ff[HORNER_STEPS][LANE_CURVATURE];

`ifndef ASSERT_OFF
   a_write_or_read: assert property (@(posedge clock) disable iff (reset)
      !((|ram_we) && pop_eval))
      else $error("table write and evaluation read taken from one beat");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/uniform_cubic_spline_eval_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_cubic_spline_eval_unit: uniform grid cubic spline evaluator
// Loads per-segment coefficients and evaluates value, slope and curvature
// in signed Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while req_stall is low, load or
// evaluate, and gives one result beat per evaluate, in request order. An
// evaluate passes through the front end (entry, a ten stage restoring
// divider that finds the segment one quotient bit per stage, clamp,
// segment start multiply, offset), the queue, the coefficient RAM read and
// three horner multiply/add stage pairs. Up to 16 beats may sit between
// intake and the back end; req_stall rises only when all of them are taken,
// so a held result does not stop intake until then. Loads are applied in
// order with evaluates, so an evaluate sees every load accepted before it.
// The nine coefficient tables are not cleared: each entry must be loaded
// before an evaluate reads it. Configuration must be written while no
// request is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module uniform_cubic_spline_eval_unit
   import usce_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_write_data,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_op,
   input  wire logic [WORD_W-1:0]      req_position,
   input  wire logic [LOAD_SEG_W-1:0]  req_load_segment,
   input  wire logic [WHICH_W-1:0]     req_load_which,
   input  wire logic signed [WORD_W-1:0] req_load_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic signed [WORD_W-1:0] rsp_spline_value,
   output      logic signed [WORD_W-1:0] rsp_spline_slope,
   output      logic signed [WORD_W-1:0] rsp_spline_curvature
);

   logic [WORD_W-1:0]  grid_spacing_ff;
   logic [NSEG_W-1:0]  num_segments_ff;
   queue_beat_type     push;
   queue_beat_type     head;
   logic               pop;
   logic [WORD_W-1:0]  value_w;
   logic [WORD_W-1:0]  slope_w;
   logic [WORD_W-1:0]  curvature_w;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_spacing_ff <= WORD_W'(32'h0001_0000);
         num_segments_ff <= NSEG_W'(1024);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_SPACING: grid_spacing_ff <= csr_write_data;
            CSR_NUM_SEGMENTS: num_segments_ff <= csr_write_data[NSEG_W-1:0];
            default: ;
         endcase
      end
   end

   // intake and segment pipeline
   usce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_position     (req_position),
      .req_load_segment (req_load_segment),
      .req_load_which   (req_load_which),
      .req_load_value   (req_load_value),
      .grid_spacing     (grid_spacing_ff),
      .num_segments     (num_segments_ff),
      .pop              (pop),
      .push             (push)
   );

   // decoupling queue
   usce_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head)
   );

   // tables and horner evaluation
   usce_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_spline_value     (value_w),
      .rsp_spline_slope     (slope_w),
      .rsp_spline_curvature (curvature_w)
   );

   assign rsp_spline_value     = $signed(value_w);
   assign rsp_spline_slope     = $signed(slope_w);
   assign rsp_spline_curvature = $signed(curvature_w);

endmodule
`default_nettype wire

>>> tb/spline_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spline_result_checker: result predictor and scoreboard of the spline unit
// Keeps its own copy of the coefficient tables and of the grid settings,
// fed from the load and register write beats that it sees. It
// works out value, slope and curvature of each accepted evaluate and
// compares them in order with the result beats, field by field.
// ----------------------------------------------------------------------------
module spline_result_checker
   import usce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]      csr_write_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_op,
   input  logic [WORD_W-1:0]      req_position,
   input  logic [LOAD_SEG_W-1:0]  req_load_segment,
   input  logic [WHICH_W-1:0]     req_load_which,
   input  logic [WORD_W-1:0]      req_load_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [WORD_W-1:0]      rsp_spline_value,
   input  logic [WORD_W-1:0]      rsp_spline_slope,
   input  logic [WORD_W-1:0]      rsp_spline_curvature,
   output int                     mismatch_count,
   output int                     pending_results
);

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [WORD_W-1:0] slope;
      logic [WORD_W-1:0] curvature;
   } spline_point_type;

   // mirrored settings and coefficient tables
   logic [WORD_W-1:0] grid_spacing;
   logic [NSEG_W-1:0] num_segments;
   logic [WORD_W-1:0] coef_table [MAX_SEGMENTS][NUM_COEFS];
   spline_point_type  expected_points [$];

   // one horner step: floor(acc * offset / 2^16) + coef, saturated to 32 bits
   function automatic logic [WORD_W-1:0] horner_step(input logic [WORD_W-1:0] acc,
                                                     input logic [WORD_W-1:0] coef,
                                                     input logic [WORD_W-1:0] offset);
      logic signed [PROD_W:0] product;
      logic signed [PROD_W:0] sum;
      product = $signed({{(PROD_W-WORD_W+1){acc[WORD_W-1]}}, acc})
              * $signed({{(PROD_W-WORD_W+1){1'b0}}, offset});
      sum = (product >>> FRAC_W) + $signed({{(PROD_W-WORD_W+1){coef[WORD_W-1]}}, coef});
      // in range when every bit above the sign matches it
      if (sum[PROD_W:WORD_W-1] == '0 || sum[PROD_W:WORD_W-1] == '1)
         return sum[WORD_W-1:0];
      return sum[PROD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

   // segment lookup, offset within the segment and the three polynomials
   function automatic spline_point_type spline_at(input logic [WORD_W-1:0] x);
      int unsigned       segs;
      int unsigned       m;
      logic [WORD_W-1:0] quotient;
      logic [WORD_W-1:0] offset;
      logic [PROD_W-1:0] span;
      spline_point_type  point;
      segs = (num_segments == 0) ? 1 :
             (num_segments > MAX_SEGMENTS) ? MAX_SEGMENTS : num_segments;
      if (grid_spacing == 0) begin
         m = segs - 1;
         offset = '0;
      end else begin
         quotient = x / grid_spacing;
         m = (quotient > segs - 1) ? segs - 1 : quotient;
         span = m;
         span = x - span * grid_spacing;
         offset = (span > grid_spacing) ? grid_spacing : span[WORD_W-1:0];
      end
      point.value = coef_table[m][COEF_D];
      point.value = horner_step(point.value, coef_table[m][COEF_C], offset);
      point.value = horner_step(point.value, coef_table[m][COEF_B], offset);
      point.value = horner_step(point.value, coef_table[m][COEF_A], offset);
      point.slope = coef_table[m][COEF_DD];
      point.slope = horner_step(point.slope, coef_table[m][COEF_DC], offset);
      point.slope = horner_step(point.slope, coef_table[m][COEF_DB], offset);
      point.curvature = coef_table[m][COEF_DDD];
      point.curvature = horner_step(point.curvature, coef_table[m][COEF_DDC], offset);
      return point;
   endfunction

   task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // watch register writes, result beats and request beats at each edge
   always @(posedge clock) begin : monitor
      spline_point_type oldest;
      if (reset) begin
         grid_spacing = 1 << FRAC_W;
         num_segments = MAX_SEGMENTS;
         expected_points.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_GRID_SPACING)
               grid_spacing = csr_write_data;
            else if (csr_index == CSR_NUM_SEGMENTS)
               num_segments = csr_write_data[NSEG_W-1:0];
         end
         // result beat against the oldest evaluate
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: result beat with no evaluate waiting, got %h %h %h", $time,
                           rsp_spline_value, rsp_spline_slope, rsp_spline_curvature);
            end else begin
               oldest = expected_points.pop_front();
               compare_field("value", oldest.value, rsp_spline_value);
               compare_field("slope", oldest.slope, rsp_spline_slope);
               compare_field("curvature", oldest.curvature, rsp_spline_curvature);
            end
         end
         // request beat: evaluate predicts, load updates the tables
         if (req_valid && !req_stall) begin
            if (req_op == OP_EVAL)
               expected_points.push_back(spline_at(req_position));
            else if (req_load_which < NUM_COEFS)
               coef_table[req_load_segment][req_load_which] = req_load_value;
         end
      end
      pending_results = expected_points.size();
   end

endmodule

>>> tb/uniform_cubic_spline_eval_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uniform_cubic_spline_eval_unit_test: testbench of the spline evaluator
// Loads coefficient sets and evaluates positions under a series of grid
// settings, with directed corner beats first and random beats after, while
// both channels idle and stall in several patterns. A separate checker
// predicts and compares every result; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module uniform_cubic_spline_eval_unit_test;
   import usce_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RANDOM_BEATS    = 1750;
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_BEATS     = RANDOM_BEATS / NUM_PHASES;
   localparam int RANDOM_PHASE    = 6;
   localparam int HOLD_OFF_AT     = 60;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOT_SEGMENTS    = 6;

   // corner coefficient words, in select order a .. ddd
   localparam logic [WORD_W-1:0] CORNER_WORDS [NUM_COEFS] = '{
      32'h0001_0000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF
   };
   localparam logic [WORD_W-1:0] PHASE_SPACING [NUM_PHASES] = '{
      32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_8000, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000
   };
   localparam logic [WORD_W-1:0] PHASE_SEGMENTS [NUM_PHASES] = '{
      1024, 1, 2047, 0, 16, 1024, 1, 4
   };

   typedef enum {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     csr_write_en     = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index        = CSR_GRID_SPACING;
   logic [WORD_W-1:0]        csr_write_data   = '0;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_op           = OP_LOAD;
   logic [WORD_W-1:0]        req_position     = '0;
   logic [LOAD_SEG_W-1:0]    req_load_segment = '0;
   logic [WHICH_W-1:0]       req_load_which   = COEF_A;
   logic signed [WORD_W-1:0] req_load_value   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [WORD_W-1:0] rsp_spline_value;
   logic signed [WORD_W-1:0] rsp_spline_slope;
   logic signed [WORD_W-1:0] rsp_spline_curvature;
   int                       mismatch_count;
   int                       pending_results;

   pace_type             pace = PACE_FULL;
   pace_type             phase_pace [NUM_PHASES] = '{
      PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH,
      PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH
   };
   logic                 hold_off_request = 1'b0;
   logic [WORD_W-1:0]    spacing_now  = 1 << FRAC_W;
   logic [NSEG_W-1:0]    segments_now = MAX_SEGMENTS;
   logic [NUM_COEFS-1:0] loaded_mask [MAX_SEGMENTS];
   int                   beats_sent   = 0;
   int                   quiet_cycles = 0;

   uniform_cubic_spline_eval_unit uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_position         (req_position),
      .req_load_segment     (req_load_segment),
      .req_load_which       (req_load_which),
      .req_load_value       (req_load_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_spline_value     (rsp_spline_value),
      .rsp_spline_slope     (rsp_spline_slope),
      .rsp_spline_curvature (rsp_spline_curvature)
   );

   spline_result_checker spline_check (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_position         (req_position),
      .req_load_segment     (req_load_segment),
      .req_load_which       (req_load_which),
      .req_load_value       (req_load_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_spline_value     (rsp_spline_value),
      .rsp_spline_slope     (rsp_spline_slope),
      .rsp_spline_curvature (rsp_spline_curvature),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic bit sender_rests();
      case (pace)
         PACE_SENDER_IDLE: return $urandom_range(99) < 79;
         PACE_BOTH:        return $urandom_range(99) < 23;
         default:          return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_rests();
      case (pace)
         PACE_RECEIVER_STALL: return $urandom_range(99) < 79;
         PACE_BOTH:           return $urandom_range(99) < 23;
         default:             return 1'b0;
      endcase
   endfunction

   function automatic int unsigned active_segments();
      if (segments_now == 0) return 1;
      if (segments_now > MAX_SEGMENTS) return MAX_SEGMENTS;
      return segments_now;
   endfunction

   // segment an evaluate at x reads, so that it can be loaded first
   function automatic int unsigned target_segment(input logic [WORD_W-1:0] x);
      int unsigned       segs;
      logic [WORD_W-1:0] quotient;
      segs = active_segments();
      if (spacing_now == 0) return segs - 1;
      quotient = x / spacing_now;
      return (quotient > segs - 1) ? segs - 1 : quotient;
   endfunction

   // mostly moderate words so that results do not always saturate
   function automatic logic [WORD_W-1:0] random_coef();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(1 << 19) - (1 << 18);
         4, 5:       return $urandom_range(1 << 25) - (1 << 24);
         6, 7:       return $urandom();
         default: begin
            case ($urandom_range(4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return '0;
               3:       return '1;
               default: return 1 << FRAC_W;
            endcase
         end
      endcase
   endfunction

   // positions in a few hot segments, on knots, at the ends and past the grid
   function automatic logic [WORD_W-1:0] random_position();
      int unsigned       roll;
      int unsigned       segs;
      int unsigned       hot;
      logic [PROD_W-1:0] spot;
      roll = $urandom_range(99);
      segs = active_segments();
      hot = (segs < HOT_SEGMENTS) ? segs : HOT_SEGMENTS;
      if (spacing_now == 0 || roll >= 85) return $urandom();
      if (roll < 45) begin
         spot = $urandom_range(hot - 1);
         spot = spot * spacing_now + $urandom_range(spacing_now - 1);
      end else if (roll < 60) begin
         spot = $urandom_range(1) ? segs - 1 : $urandom_range(hot - 1);
         spot = spot * spacing_now;
         if (spot != 0 && $urandom_range(1)) spot = spot - 1;
      end else if (roll < 70) begin
         case ($urandom_range(2))
            0:       return '0;
            1:       return '1;
            default: return 1;
         endcase
      end else begin
         spot = segs;
         spot = spot * spacing_now + $urandom_range(spacing_now);
      end
      if (spot[PROD_W-1:WORD_W] != 0) return $urandom();
      return spot[WORD_W-1:0];
   endfunction

   // present one request beat at a falling edge and hold it until accepted
   task automatic send_beat(input logic op, input logic [WORD_W-1:0] position,
                            input logic [LOAD_SEG_W-1:0] seg,
                            input logic [WHICH_W-1:0] which,
                            input logic [WORD_W-1:0] value);
      @(negedge clock);
      while (sender_rests()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_position     <= position;
      req_load_segment <= seg;
      req_load_which   <= which;
      req_load_value   <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD && which < NUM_COEFS) loaded_mask[seg][which] = 1'b1;
      beats_sent++;
   endtask

   // load whatever the target segment still lacks, then evaluate
   task automatic evaluate_at(input logic [WORD_W-1:0] x);
      int unsigned m;
      m = target_segment(x);
      for (int w = 0; w < NUM_COEFS; w++)
         if (!loaded_mask[m][w]) send_beat(OP_LOAD, $urandom(), m, w, random_coef());
      send_beat(OP_EVAL, x, $urandom(), $urandom(), $urandom());
   endtask

   task automatic wait_for_results(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // both registers written back to back once the pipeline is empty
   task automatic write_config(input logic [WORD_W-1:0] spacing,
                               input logic [WORD_W-1:0] segments);
      wait_for_results(DRAIN_CYCLES);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_GRID_SPACING;
      csr_write_data <= spacing;
      @(negedge clock);
      csr_index      <= CSR_NUM_SEGMENTS;
      csr_write_data <= segments;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      spacing_now  = spacing;
      segments_now = segments[NSEG_W-1:0];
   endtask

   task automatic random_item();
      int unsigned roll;
      int unsigned seg;
      roll = $urandom_range(99);
      if (roll < 55) begin
         evaluate_at(random_position());
      end else if (roll < 72) begin
         // overwrite one word, mostly in the hot segments
         seg = ($urandom_range(3) != 0) ? $urandom_range(HOT_SEGMENTS - 1)
                                        : $urandom_range(MAX_SEGMENTS - 1);
         send_beat(OP_LOAD, $urandom(), seg, $urandom_range(NUM_COEFS - 1), random_coef());
      end else if (roll < 78) begin
         send_beat(OP_LOAD, $urandom(), $urandom(),
                   $urandom_range((1 << WHICH_W) - 1, COEF_NONE), $urandom());
      end else if (roll < 86) begin
         seg = $urandom_range(MAX_SEGMENTS - 1);
         for (int w = 0; w < NUM_COEFS; w++)
            send_beat(OP_LOAD, $urandom(), seg, w, random_coef());
      end else if (roll < 87) begin
         wait_for_results(0);
      end else begin
         evaluate_at(random_position());
      end
   endtask

   // receiver: random stalls per pace, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= receiver_rests();
         end
      end
   end

   // watchdog on cycles with no beat accepted on either channel
   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [WORD_W-1:0] spacing;
      logic [WORD_W-1:0] segments;
      int                phase_start;
      bit                hold_done;
      for (int s = 0; s < MAX_SEGMENTS; s++) loaded_mask[s] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corner words, bad selects, ends of the grid at reset settings
      for (int w = 0; w < NUM_COEFS; w++)
         send_beat(OP_LOAD, $urandom(), 0, w, CORNER_WORDS[w]);
      evaluate_at('0);
      evaluate_at(32'h0000_FFFF);
      send_beat(OP_LOAD, $urandom(), 0, COEF_NONE, 32'h1234_5678);
      send_beat(OP_LOAD, $urandom(), 0, '1, '1);
      evaluate_at(32'h0000_8000);
      evaluate_at('1);
      evaluate_at(32'h03FF_0000);

      // random phases, each under its own grid settings and pace
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         spacing  = PHASE_SPACING[ph];
         segments = PHASE_SEGMENTS[ph];
         if (ph == RANDOM_PHASE) begin
            spacing  = $urandom_range(1 << 20, 1);
            segments = $urandom_range(MAX_SEGMENTS, 1);
         end
         write_config(spacing, segments);
         pace = phase_pace[ph];
         phase_start = beats_sent;
         hold_done = 1'b0;
         while (beats_sent - phase_start < PHASE_BEATS) begin
            // at full rate, hold results back long enough to fill the block
            if (pace == PACE_FULL && !hold_done && beats_sent - phase_start >= HOLD_OFF_AT) begin
               hold_off_request = 1'b1;
               hold_done = 1'b1;
            end
            random_item();
         end
      end

      wait_for_results(DRAIN_CYCLES);
      if (mismatch_count == 0 && pending_results == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> uniform_cubic_spline_eval_unit.f
hw/rtl/usce_pkg.sv
hw/rtl/usce_ram.sv
hw/rtl/usce_front.sv
hw/rtl/usce_queue.sv
hw/rtl/usce_back.sv
hw/rtl/uniform_cubic_spline_eval_unit.sv
tb/spline_result_checker.sv
tb/uniform_cubic_spline_eval_unit_test.sv
